// ----- hw/rtl/psi_section_reassembler_defines.svh -----
// ----------------------------------------------------------------------------
// psi section reassembler assertion macros
// shared concurrent assertion forms, clocked with synchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef PSI_SECTION_REASSEMBLER_DEFINES_SVH
`define PSI_SECTION_REASSEMBLER_DEFINES_SVH

// same-cycle implication
`define PSI_SR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("psi_sr same-cycle check failed");

// next-cycle implication
`define PSI_SR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("psi_sr next-cycle check failed");

`endif

// ----- hw/rtl/psi_sr_pkg.sv -----
// ----------------------------------------------------------------------------
// psi section reassembler package
// item and result types, result kind codes and sizing constants
// ----------------------------------------------------------------------------
`default_nettype none

package psi_sr_pkg;

    localparam int SECTION_BUFFER_BYTES_DEF = 4096;

    // result queue depth, two slots reserved per accepted item
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_ABANDON  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [7:0] payload_length;
        logic       unit_start;
        logic [3:0] counter;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [12:0] offset;
        logic [12:0] section_bytes;
        logic        last;
    } t_result;

    // results produced by one item, in order
    typedef struct packed {
        logic [1:0]        count;
        t_result [1:0]     res;
    } t_push;

endpackage

`default_nettype wire

// ----- hw/rtl/psi_sr_chan_if.sv -----
// ----------------------------------------------------------------------------
// psi section reassembler channel
// valid/ready channel carrying one payload struct per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface psi_sr_chan_if #(
    parameter type T = logic [7:0]
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/psi_sr_core.sv -----
// ----------------------------------------------------------------------------
// psi section reassembler core
// continuity, pointer field and section tracking, up to two results per item
// ----------------------------------------------------------------------------
`default_nettype none

module psi_sr_core #(
    parameter int SECTION_BUFFER_BYTES = psi_sr_pkg::SECTION_BUFFER_BYTES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire psi_sr_pkg::t_item i_item,
    output psi_sr_pkg::t_push     o_push
);

    typedef enum logic [2:0] {
        M_IDLE  = 3'd0,
        M_SECT  = 3'd1,
        M_STUFF = 3'd2,
        M_TAIL  = 3'd3,
        M_TSKIP = 3'd4
    } t_mode;

    localparam logic [13:0] BUF_LIMIT = 14'(SECTION_BUFFER_BYTES);

    t_mode       r_mode, n_mode;
    logic [4:0]  r_cc, n_cc;
    logic [12:0] r_bc, n_bc;
    logic [7:0]  r_hdr [3];
    logic [7:0]  n_hdr [3];
    logic [7:0]  r_ptr, n_ptr;

    psi_sr_pkg::t_push n_push;

    function automatic psi_sr_pkg::t_result mk_res(logic [1:0] kind, logic [7:0] b,
                                                  logic [12:0] off, logic [12:0] len);
        psi_sr_pkg::t_result r;
        r.kind          = kind;
        r.out_byte      = b;
        r.offset        = off;
        r.section_bytes = len;
        r.last          = 1'b0;
        return r;
    endfunction

    always_comb begin
        logic        go;
        logic        ok;
        logic        partial;
        logic [12:0] bc1;
        logic [12:0] total;
        logic [7:0]  d;
        logic [7:0]  idx;

        n_mode = r_mode;
        n_cc   = r_cc;
        n_bc   = r_bc;
        n_hdr  = r_hdr;
        n_ptr  = r_ptr;
        n_push = '0;
        go     = 1'b1;
        bc1    = '0;
        total  = '0;
        d      = i_item.data_byte;
        idx    = i_item.byte_index;
        ok      = r_cc[4] && ((r_cc[3:0] + 4'd1) == i_item.counter);
        partial = (r_mode == M_SECT || r_mode == M_TAIL) && (r_bc != 13'd0);

        if (!i_accept) begin
            go = 1'b0;
        end else if (i_item.payload_length == 8'd0) begin
            go = 1'b0;
            if (i_item.unit_start && idx == 8'd0) begin
                if (partial) begin
                    n_push.res[n_push.count[0]] = mk_res(psi_sr_pkg::KIND_ABANDON, '0, '0, '0);
                    n_push.count = n_push.count + 2'd1;
                end
                n_cc   = '0;
                n_bc   = '0;
                n_mode = M_IDLE;
            end
        end else if (idx >= i_item.payload_length) begin
            go = 1'b0;
        end else if (idx == 8'd0) begin
            if (i_item.unit_start) begin
                // pointer field
                if (ok && d != 8'd0 && d < i_item.payload_length && r_mode == M_SECT) begin
                    n_mode = M_TAIL;
                end else begin
                    if (partial) begin
                        n_push.res[n_push.count[0]] =
                            mk_res(psi_sr_pkg::KIND_ABANDON, '0, '0, '0);
                        n_push.count = n_push.count + 2'd1;
                    end
                    n_bc   = '0;
                    n_mode = (d != 8'd0) ? M_TSKIP : M_SECT;
                end
                n_ptr = d;
                n_cc  = {1'b1, i_item.counter};
                go    = 1'b0;
            end else if (!ok) begin
                if (partial) begin
                    n_push.res[n_push.count[0]] = mk_res(psi_sr_pkg::KIND_ABANDON, '0, '0, '0);
                    n_push.count = n_push.count + 2'd1;
                end
                n_cc   = '0;
                n_bc   = '0;
                n_mode = M_IDLE;
                go     = 1'b0;
            end else begin
                n_cc = {1'b1, i_item.counter};
                if (r_mode == M_TAIL || r_mode == M_TSKIP) begin
                    if (partial) begin
                        n_push.res[n_push.count[0]] =
                            mk_res(psi_sr_pkg::KIND_ABANDON, '0, '0, '0);
                        n_push.count = n_push.count + 2'd1;
                    end
                    n_bc   = '0;
                    n_mode = M_SECT;
                end
            end
        end else begin
            // index jumped past the pointer: close the tail
            if (n_mode == M_TAIL && idx > r_ptr) begin
                if (n_bc != 13'd0) begin
                    n_push.res[n_push.count[0]] = mk_res(psi_sr_pkg::KIND_ABANDON, '0, '0, '0);
                    n_push.count = n_push.count + 2'd1;
                end
                n_bc   = '0;
                n_mode = M_SECT;
            end
            if (n_mode == M_TSKIP) begin
                if (idx <= r_ptr) begin
                    go = 1'b0;
                end else begin
                    n_bc   = '0;
                    n_mode = M_SECT;
                end
            end
        end

        if (go && (n_mode == M_SECT || n_mode == M_TAIL)) begin
            if (n_bc == 13'd0 && d == 8'hff) begin
                // stuffing at section start
                n_mode = (n_mode == M_TAIL) ? M_TSKIP : M_STUFF;
            end else begin
                n_push.res[n_push.count[0]] = mk_res(psi_sr_pkg::KIND_BYTE, d, n_bc, '0);
                n_push.count = n_push.count + 2'd1;
                if (n_bc < 13'd3) begin
                    n_hdr[n_bc[1:0]] = d;
                end
                bc1   = n_bc + 13'd1;
                n_bc  = bc1;
                total = 13'd3 + {1'b0, n_hdr[1][3:0], n_hdr[2]};
                if (bc1 >= 13'd3) begin
                    if (bc1 == 13'd3 && {1'b0, total} > BUF_LIMIT) begin
                        n_push.res[n_push.count[0]] =
                            mk_res(psi_sr_pkg::KIND_ABANDON, '0, '0, '0);
                        n_push.count = n_push.count + 2'd1;
                        n_bc   = '0;
                        n_mode = (n_mode == M_TAIL) ? M_TSKIP : M_STUFF;
                    end else if (bc1 == total) begin
                        n_push.res[n_push.count[0]] =
                            mk_res(psi_sr_pkg::KIND_COMPLETE, '0, '0, total);
                        n_push.count = n_push.count + 2'd1;
                        n_bc = '0;
                        if (n_mode == M_TAIL) begin
                            n_mode = M_TSKIP;
                        end
                    end
                end
                // last tail byte
                if (n_mode == M_TAIL && idx == r_ptr) begin
                    if (n_bc != 13'd0) begin
                        n_push.res[n_push.count[0]] =
                            mk_res(psi_sr_pkg::KIND_ABANDON, '0, '0, '0);
                        n_push.count = n_push.count + 2'd1;
                    end
                    n_bc   = '0;
                    n_mode = M_SECT;
                end
            end
        end

        if (n_push.count == 2'd1) begin
            n_push.res[0].last = 1'b1;
        end else if (n_push.count == 2'd2) begin
            n_push.res[1].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_cc   <= '0;
            r_bc   <= '0;
            r_ptr  <= '0;
            r_hdr  <= '{default: '0};
        end else begin
            r_mode <= n_mode;
            r_cc   <= n_cc;
            r_bc   <= n_bc;
            r_ptr  <= n_ptr;
            r_hdr  <= n_hdr;
        end
    end

    assign o_push = n_push;

endmodule

`default_nettype wire

// ----- hw/rtl/psi_sr_queue.sv -----
// ----------------------------------------------------------------------------
// psi section reassembler result queue
// small register queue taking up to two results per cycle, one out per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module psi_sr_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire psi_sr_pkg::t_push   i_push,
    input  wire logic                i_pop,
    output psi_sr_pkg::t_result      o_head,
    output logic                     o_valid,
    output logic                     o_room
);

    localparam int PW = psi_sr_pkg::QUEUE_PTR_W;
    localparam int CW = PW + 1;

    psi_sr_pkg::t_result r_mem [psi_sr_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.res[0];
        end
        if (i_push.count == 2'd2) begin
            r_mem[PW'(r_wr + PW'(1))] <= i_push.res[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= PW'(r_wr + PW'(i_push.count));
            r_rd    <= PW'(r_rd + PW'(i_pop));
            r_count <= CW'(r_count + CW'(i_push.count) - CW'(i_pop));
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_valid = (r_count != '0);
    // room for the worst case of one item
    assign o_room  = (r_count <= CW'(psi_sr_pkg::QUEUE_DEPTH - 2));

endmodule

`default_nettype wire

// ----- hw/rtl/psi_section_reassembler.sv -----
// ----------------------------------------------------------------------------
// psi section reassembler
// rebuilds psi sections from the payload bytes of one filtered ts pid
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                              per item
//  -------  ---  ---------------------------------------------------  --------
//  i_in     in   data_byte, byte_index, payload_length, unit_start,   1
//                counter
//  o_out    out  kind, out_byte, offset, section_bytes, last          0 to 2
//
//  one input transaction per cycle while ready; its results are computed
//  in the same cycle from section state and enter a four-entry result queue
//  the queue drains one result per cycle while o_out is ready, so the two
//  results of an item (a byte plus a complete or abandoned report) go in turn
//  input is ready while the queue has room for two results
//  synchronous active-low reset: idle mode, no valid counter, empty queue
// ----------------------------------------------------------------------------
`default_nettype none
`include "psi_section_reassembler_defines.svh"

module psi_section_reassembler #(
    parameter int SECTION_BUFFER_BYTES = psi_sr_pkg::SECTION_BUFFER_BYTES_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    psi_sr_chan_if.sink    i_in,
    psi_sr_chan_if.source  o_out
);

    logic                w_accept;
    logic                w_pop;
    logic                w_room;
    logic                w_valid;
    psi_sr_pkg::t_push   w_push;
    psi_sr_pkg::t_result w_head;

    // input transaction handshake
    assign w_accept  = i_in.valid && w_room;
    assign i_in.ready = w_room;

    // section tracking and result generation
    psi_sr_core #(
        .SECTION_BUFFER_BYTES(SECTION_BUFFER_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_in.payload),
        .o_push   (w_push)
    );

    // results wait here while the sink stalls
    psi_sr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_valid (w_valid),
        .o_room  (w_room)
    );

    assign w_pop         = w_valid && o_out.ready;
    assign o_out.valid   = w_valid;
    assign o_out.payload = w_head;

    // a stalled input means results are pending
    `PSI_SR_ASSERT_IMPL(a_stall_pending, i_clk, i_rst_n, !w_room, w_valid)
    // after any push, the output shows a valid result next cycle
    `PSI_SR_ASSERT_NEXT(a_push_visible, i_clk, i_rst_n, w_push.count != 2'd0, w_valid)
    // completed sections carry at least their three header bytes
    `PSI_SR_ASSERT_IMPL(a_complete_len, i_clk, i_rst_n,
        w_valid && w_head.kind == psi_sr_pkg::KIND_COMPLETE, w_head.section_bytes >= 13'd3)

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// psi section reassembler testbench
// drives ts payload bytes, packetized from generated psi sections, through
// the block and checks every section byte, complete and abandoned report
// against a cycle-free predictor of the reassembly rules
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    localparam int BUFFER_BYTES  = psi_sr_pkg::SECTION_BUFFER_BYTES_DEF;
    localparam int CYCLE_LIMIT   = 250000;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_PAYLOAD   = 184;

    // where the byte stream of the pid currently stands
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_SECTION,
        MODE_STUFF,
        MODE_TAIL,
        MODE_TAIL_SKIP
    } t_rx_mode;

    typedef bit [7:0] t_byte_q[$];

    logic i_clk;
    logic i_rst_n;

    psi_sr_chan_if #(.T(psi_sr_pkg::t_item))   in_if ();
    psi_sr_chan_if #(.T(psi_sr_pkg::t_result)) out_if ();

    psi_section_reassembler #(
        .SECTION_BUFFER_BYTES(BUFFER_BYTES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // results still owed by the block, oldest first
    psi_sr_pkg::t_result section_results_due[$];
    // results of the byte being predicted
    psi_sr_pkg::t_result byte_results[$];

    // predictor state, same meaning as the block's state after reset
    bit       cc_seen;
    bit [3:0] last_cc;
    int       sect_fill;
    bit [7:0] sect_head [3];
    int       tail_pointer;
    t_rx_mode rx_mode = MODE_IDLE;

    // stimulus control
    int       send_idle_pct;
    int       recv_idle_pct;
    int       mismatches;
    int       cycle_count;
    int       bytes_sent;
    bit [3:0] cc_next;

    // section byte stream waiting to be cut into packets, with start marks
    t_byte_q  stream_bytes;
    bit       stream_starts[$];

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void push_result(input logic [1:0] kind, input int b, input int off,
                                        input int len);
        psi_sr_pkg::t_result r;
        r.kind          = kind;
        r.out_byte      = 8'(b);
        r.offset        = 13'(off);
        r.section_bytes = 13'(len);
        r.last          = 1'b0;
        byte_results.push_back(r);
    endfunction

    // a section that has bytes and is being collected gets dropped
    function automatic void abandon_open_section();
        if ((rx_mode == MODE_SECTION || rx_mode == MODE_TAIL) && sect_fill > 0)
            push_result(psi_sr_pkg::KIND_ABANDON, 0, 0, 0);
    endfunction

    function automatic void reassemble_byte(input psi_sr_pkg::t_item it);
        int       d;
        int       idx;
        int       plen;
        int       total;
        bit       us;
        bit [3:0] cnt;
        bit [3:0] cc_succ;
        bit       cc_match;
        d        = it.data_byte;
        idx      = it.byte_index;
        plen     = it.payload_length;
        us       = it.unit_start;
        cnt      = it.counter;
        cc_succ  = last_cc + 4'd1;
        cc_match = cc_seen && (cc_succ == cnt);

        // empty packet: only a unit start at byte 0 matters, it resyncs
        if (plen == 0) begin
            if (us && idx == 0) begin
                abandon_open_section();
                cc_seen   = 1'b0;
                last_cc   = 4'd0;
                sect_fill = 0;
                rx_mode   = MODE_IDLE;
            end
            return;
        end
        if (idx >= plen)
            return;

        if (idx == 0) begin
            // pointer field of a unit start packet
            if (us) begin
                if (cc_match && d > 0 && d + 1 <= plen && rx_mode == MODE_SECTION) begin
                    rx_mode = MODE_TAIL;
                end else begin
                    abandon_open_section();
                    sect_fill = 0;
                    if (d > 0)
                        rx_mode = MODE_TAIL_SKIP;
                    else
                        rx_mode = MODE_SECTION;
                end
                tail_pointer = d;
                cc_seen      = 1'b1;
                last_cc      = cnt;
                return;
            end
            // continuity break drops everything up to the next unit start
            if (!cc_match) begin
                abandon_open_section();
                cc_seen   = 1'b0;
                last_cc   = 4'd0;
                sect_fill = 0;
                rx_mode   = MODE_IDLE;
                return;
            end
            last_cc = cnt;
            if (rx_mode == MODE_TAIL || rx_mode == MODE_TAIL_SKIP) begin
                abandon_open_section();
                sect_fill = 0;
                rx_mode   = MODE_SECTION;
            end
        end else begin
            // index jumped past the pointer: tail closes as at its end
            if (rx_mode == MODE_TAIL && idx > tail_pointer) begin
                abandon_open_section();
                sect_fill = 0;
                rx_mode   = MODE_SECTION;
            end
            if (rx_mode == MODE_TAIL_SKIP) begin
                if (idx <= tail_pointer)
                    return;
                sect_fill = 0;
                rx_mode   = MODE_SECTION;
            end
        end

        if (rx_mode != MODE_SECTION && rx_mode != MODE_TAIL)
            return;

        // 0xff where a section would start is stuffing
        if (sect_fill == 0 && d == 8'hff) begin
            if (rx_mode == MODE_TAIL)
                rx_mode = MODE_TAIL_SKIP;
            else
                rx_mode = MODE_STUFF;
            return;
        end

        push_result(psi_sr_pkg::KIND_BYTE, d, sect_fill, 0);
        if (sect_fill < 3)
            sect_head[sect_fill] = 8'(d);
        sect_fill++;
        if (sect_fill >= 3) begin
            total = 3 + {sect_head[1][3:0], sect_head[2]};
            if (sect_fill == 3 && total > BUFFER_BYTES) begin
                // too long for the buffer: drop it and skip its body
                push_result(psi_sr_pkg::KIND_ABANDON, 0, 0, 0);
                sect_fill = 0;
                if (rx_mode == MODE_TAIL)
                    rx_mode = MODE_TAIL_SKIP;
                else
                    rx_mode = MODE_STUFF;
            end else if (sect_fill == total) begin
                push_result(psi_sr_pkg::KIND_COMPLETE, 0, 0, total);
                sect_fill = 0;
                if (rx_mode == MODE_TAIL)
                    rx_mode = MODE_TAIL_SKIP;
            end
        end
        // last tail byte: whatever is left open there is dropped
        if (rx_mode == MODE_TAIL && idx == tail_pointer) begin
            abandon_open_section();
            sect_fill = 0;
            rx_mode   = MODE_SECTION;
        end
    endfunction

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    // one byte transaction, with random gaps before it
    task automatic send_item(input psi_sr_pkg::t_item it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= it;
        do @(posedge i_clk); while (!in_if.ready);
        byte_results.delete();
        reassemble_byte(it);
        if (byte_results.size() > 0)
            byte_results[byte_results.size() - 1].last = 1'b1;
        foreach (byte_results[i])
            section_results_due.push_back(byte_results[i]);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_loose(input int d, input int idx, input int plen, input bit us,
                              input bit [3:0] cc);
        psi_sr_pkg::t_item it;
        it.data_byte      = 8'(d);
        it.byte_index     = 8'(idx);
        it.payload_length = 8'(plen);
        it.unit_start     = us;
        it.counter        = cc;
        send_item(it);
    endtask

    // one ts packet payload, optionally missing one byte index
    task automatic send_packet(input t_byte_q pkt, input bit us, input bit [3:0] cc,
                               input int skip_index);
        for (int i = 0; i < pkt.size(); i++) begin
            if (i != skip_index)
                send_loose(pkt[i], i, pkt.size(), us, cc);
        end
    endtask

    // sender holds off until the block owes nothing
    task automatic hold_until_drained();
        in_if.valid <= 1'b0;
        @(negedge i_clk);
        while (section_results_due.size() != 0)
            @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // section stream generation and packetizing
    // ------------------------------------------------------------------------
    function automatic void push_stream_byte(input int b, input bit start);
        stream_bytes.push_back(8'(b));
        stream_starts.push_back(start);
    endfunction

    function automatic void queue_section(input int len, input int body);
        bit [11:0] len_field;
        len_field = 12'(len);
        // table id never 0xff, upper nibble of byte 1 random flag bits
        push_stream_byte($urandom_range(254), 1'b1);
        push_stream_byte({4'($urandom_range(15)), len_field[11:8]}, 1'b0);
        push_stream_byte(len_field[7:0], 1'b0);
        repeat (body)
            push_stream_byte($urandom_range(255), 1'b0);
    endfunction

    function automatic void queue_random_section();
        int r;
        int len;
        r = $urandom_range(99);
        if (r < 8) begin
            // stuffing where a section would begin
            push_stream_byte(8'hff, 1'b1);
            repeat ($urandom_range(4))
                push_stream_byte($urandom_range(255), 1'b0);
        end else if (r < 80) begin
            len = $urandom_range(30);
            queue_section(len, len);
        end else if (r < 95) begin
            len = $urandom_range(300, 31);
            queue_section(len, len);
        end else begin
            // header says longer than the buffer, body is skipped anyway
            len = $urandom_range(4095, BUFFER_BYTES - 2);
            queue_section(len, $urandom_range(10));
        end
    endfunction

    function automatic int pick_payload_length();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(20, 1);
        else if (r < 90)
            return $urandom_range(MAX_PAYLOAD - 1, 21);
        return MAX_PAYLOAD;
    endfunction

    // cut the stream into packets; unit start and pointer where a section
    // begins inside the packet, random packet faults when noisy
    task automatic send_stream(input bit noisy, input bit full_packets);
        t_byte_q pkt;
        int      plen;
        int      ptr;
        int      roll;
        int      skip;
        bit      us;
        while (stream_bytes.size() > 0) begin
            plen = full_packets ? MAX_PAYLOAD : pick_payload_length();
            if (!full_packets && plen > stream_bytes.size() + 2)
                plen = stream_bytes.size() + 2;
            ptr = -1;
            for (int k = 0; k < plen - 1 && k < stream_bytes.size(); k++) begin
                if (stream_starts[k]) begin
                    ptr = k;
                    break;
                end
            end
            us  = (ptr >= 0);
            pkt = {};
            if (us)
                pkt.push_back(8'(ptr));
            while (pkt.size() < plen) begin
                if (stream_bytes.size() > 0) begin
                    pkt.push_back(stream_bytes.pop_front());
                    void'(stream_starts.pop_front());
                end else begin
                    pkt.push_back(8'hff);
                end
            end

            skip = -1;
            roll = noisy ? $urandom_range(99) : 99;
            case (roll)
                0, 1: cc_next = cc_next + 4'd1;                   // lost packet
                2: if (us) pkt[0] = 8'($urandom_range(255, plen)); // pointer past payload
                3: if (plen > 2) skip = $urandom_range(plen - 1, 1); // index jump
                4: send_loose($urandom_range(255), $urandom_range(1) ? 0 : $urandom_range(183),
                              0, 1'($urandom_range(1)), 4'($urandom_range(15)));
                5: pkt[$urandom_range(plen - 1)] = 8'($urandom_range(255));
                default: ;
            endcase
            send_packet(pkt, us, cc_next, skip);
            // repeated counter
            if (roll == 6)
                send_packet(pkt, us, cc_next, skip);
            // stray byte beyond the payload
            if (roll == 7 && plen < MAX_PAYLOAD)
                send_loose($urandom_range(255), $urandom_range(MAX_PAYLOAD - 1, plen), plen,
                           us, cc_next);
            cc_next = cc_next + 4'd1;
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_special_cases();
        t_byte_q pkt;
        // section header only, left open
        pkt = {8'h00, 8'h42, 8'hb0, 8'h05};
        send_packet(pkt, 1'b1, 4'd0, -1);
        // byte beyond the payload, then an empty packet, both ignored
        send_loose(8'haa, 7, 4, 1'b0, 4'd1);
        send_loose(8'h5a, 0, 0, 1'b0, 4'd1);
        // empty unit start packet drops the open section
        send_loose(8'h00, 0, 0, 1'b1, 4'd2);
        // stuffing right after the pointer
        pkt = {8'h00, 8'hff, 8'h12};
        send_packet(pkt, 1'b1, 4'd5, -1);
        // largest length field, over the buffer
        pkt = {8'h00, 8'h00, 8'h1f, 8'hff};
        send_packet(pkt, 1'b1, 4'd6, -1);
        // zero length section, then stuffing
        pkt = {8'h00, 8'h80, 8'hf0, 8'h00, 8'hff};
        send_packet(pkt, 1'b1, 4'd7, -1);
        // open section, then a pointer past the payload
        pkt = {8'h00, 8'h42, 8'hb0};
        send_packet(pkt, 1'b1, 4'd8, -1);
        pkt = {8'hff, 8'h13};
        send_packet(pkt, 1'b1, 4'd9, -1);
        cc_next = 4'd10;
    endtask

    task automatic test_random_sections(input int n, input int send_pct, input int recv_pct);
        int stop_at;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at       = bytes_sent + n;
        while (bytes_sent < stop_at) begin
            repeat ($urandom_range(3, 1))
                queue_random_section();
            send_stream(1'b1, 1'b0);
        end
    endtask

    // header giving exactly the buffer size is kept open, a header one byte
    // over the buffer in the next unit start packet is dropped
    task automatic test_largest_section();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_section(BUFFER_BYTES - 3, 4);
        send_stream(1'b0, 1'b0);
        queue_section(BUFFER_BYTES - 2, 4);
        send_stream(1'b0, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------------
    always @(negedge i_clk)
        out_if.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);

    function automatic void check_field(input string field, input logic [12:0] want,
                                        input logic [12:0] got);
        if (got !== want) begin
            mismatches++;
            $error("%s: expected %0d, actual %0d", field, want, got);
        end
    endfunction

    // compare each result transaction against the oldest expectation
    always @(posedge i_clk) begin : result_check
        psi_sr_pkg::t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (section_results_due.size() == 0) begin
                mismatches++;
                $error("result with nothing expected: kind %0d, byte %0d",
                       out_if.payload.kind, out_if.payload.out_byte);
            end else begin
                want = section_results_due.pop_front();
                check_field("kind", want.kind, out_if.payload.kind);
                check_field("out_byte", want.out_byte, out_if.payload.out_byte);
                check_field("offset", want.offset, out_if.payload.offset);
                check_field("section_bytes", want.section_bytes, out_if.payload.section_bytes);
                check_field("last", want.last, out_if.payload.last);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        out_if.ready  = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_special_cases();
        hold_until_drained();
        // sender mostly busy, receiver mostly stalled
        test_random_sections(270, 16, 77);
        hold_until_drained();
        // sender mostly idle, receiver mostly ready
        test_random_sections(270, 77, 16);
        hold_until_drained();
        // back to back
        test_random_sections(260, 0, 0);
        test_largest_section();

        in_if.valid <= 1'b0;
        @(negedge i_clk);
        while (section_results_due.size() != 0)
            @(negedge i_clk);
        // any late extra result shows up as unexpected here
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
